@@ design/pmw_pkg.sv @@
// shared types, constants and helpers of the two-class pattern window matcher
// no dependencies; used by pmw_map, pmw_cell and the core
`default_nettype none

package pmw_pkg;

    localparam int POS_BITS   = 24;
    localparam int CODE_BITS  = 4;
    localparam int NUM_CELLS  = 8;
    localparam int NUM_LETTERS = 4;
    localparam int LETTER_BITS = 7;
    localparam int WIN_BITS   = CODE_BITS * NUM_CELLS;
    localparam int START_BITS = 24;

    localparam logic [WIN_BITS-1:0] QUAD_ONES  = 32'h1111_1111;
    localparam logic [WIN_BITS-1:0] QUAD_HIGHS = 32'h8888_8888;

    typedef logic [POS_BITS-1:0]                      t_pos;
    typedef logic [START_BITS-1:0]                    t_start;
    typedef logic [CODE_BITS-1:0]                     t_code;
    typedef logic [WIN_BITS-1:0]                      t_word;
    typedef logic [NUM_LETTERS-1:0][LETTER_BITS-1:0]  t_letters;

    typedef enum logic [2:0] {
        REG_LETTER_ZERO  = 3'd0,
        REG_LETTER_ONE   = 3'd1,
        REG_LETTER_TWO   = 3'd2,
        REG_LETTER_THREE = 3'd3,
        REG_LEFT_PATTERN = 3'd4,
        REG_RIGHT_PATTERN = 3'd5
    } t_reg_idx;

    // masked nibbles a cell hands to the hit check
    typedef struct packed {
        t_code left;
        t_code right;
    } t_cell_tap;

    // ascii lower-case letters fold onto upper case
    function automatic logic [LETTER_BITS-1:0] fold_case(input logic [LETTER_BITS-1:0] c);
        logic [LETTER_BITS-1:0] f;
        f = c;
        if (c >= 7'd97 && c <= 7'd122) begin
            f = c - 7'd32;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

@@ design/pmw_map.sv @@
// character to one-hot code mapper
// depends on pmw_pkg for widths and the case fold helper
`default_nettype none

module pmw_map (
    input  wire logic [15:0]        i_char,
    input  wire pmw_pkg::t_letters  i_letters,
    output pmw_pkg::t_code          o_code
);

    logic [pmw_pkg::LETTER_BITS-1:0] w_folded;

    assign w_folded = pmw_pkg::fold_case(i_char[pmw_pkg::LETTER_BITS-1:0]);

    // higher letter index wins when two registers agree
    always_comb begin
        o_code = '0;
        if (i_char[15:pmw_pkg::LETTER_BITS] == '0) begin
            for (int i = 0; i < pmw_pkg::NUM_LETTERS; i++) begin
                if (pmw_pkg::fold_case(i_letters[i]) == w_folded) begin
                    o_code = pmw_pkg::t_code'(1) << i;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/pmw_cell.sv @@
// one window cell: holds a code nibble and masks its next value with both patterns
// depends on pmw_pkg for the code and tap types
`default_nettype none

module pmw_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_shift,
    input  wire logic               i_clear,
    input  wire pmw_pkg::t_code     i_code,
    input  wire pmw_pkg::t_code     i_left_nib,
    input  wire pmw_pkg::t_code     i_right_nib,
    output pmw_pkg::t_code          o_code,
    output pmw_pkg::t_cell_tap      o_tap
);

    pmw_pkg::t_code r_code;
    pmw_pkg::t_code n_code;

    assign n_code      = i_clear ? '0 : i_code;
    assign o_tap.left  = n_code & i_left_nib;
    assign o_tap.right = n_code & i_right_nib;
    assign o_code      = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
        end else if (i_shift) begin
            r_code <= n_code;
        end
    end

endmodule

`default_nettype wire

@@ design/two_class_pattern_window_matcher_core.sv @@
// a result is registered and presented in the cycle after its input transaction is accepted
// throughput: one character per cycle unless the result stalls; the eight-cell shift
//   chain and the hit check on the shifted window settle within the accepting cycle
// a result register decouples the sides; input stays ready while it is empty or taken
// reset (synchronous, active low) clears the window, the position, the result
//   register valid and loads letters A..D with both patterns zero
`default_nettype none

module two_class_pattern_window_matcher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // [15:0] char_code, [39:16] start_offset
    input  wire logic        i_s_tuser,   // [0] restart
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [23:0] match_start
    output logic             o_m_tuser,   // [0] matched
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);

    pmw_pkg::t_letters r_letters;
    pmw_pkg::t_word    r_left;
    pmw_pkg::t_word    r_right;
    pmw_pkg::t_pos     r_next_pos;
    logic              r_out_valid;
    logic              r_matched;
    pmw_pkg::t_start   r_start;

    logic              w_accept;
    logic              w_restart;
    pmw_pkg::t_pos     w_pos;
    pmw_pkg::t_code    w_new_code;
    pmw_pkg::t_code    w_cell_code [pmw_pkg::NUM_CELLS];
    pmw_pkg::t_cell_tap w_tap      [pmw_pkg::NUM_CELLS];
    pmw_pkg::t_word    w_left_word;
    pmw_pkg::t_word    w_right_word;
    pmw_pkg::t_word    w_window;
    logic              w_hit;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_restart   = i_s_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letters[0] <= 7'd65;
            r_letters[1] <= 7'd66;
            r_letters[2] <= 7'd67;
            r_letters[3] <= 7'd68;
            r_left       <= '0;
            r_right      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                pmw_pkg::REG_LETTER_ZERO:   r_letters[0] <= i_cfg_data[6:0];
                pmw_pkg::REG_LETTER_ONE:    r_letters[1] <= i_cfg_data[6:0];
                pmw_pkg::REG_LETTER_TWO:    r_letters[2] <= i_cfg_data[6:0];
                pmw_pkg::REG_LETTER_THREE:  r_letters[3] <= i_cfg_data[6:0];
                pmw_pkg::REG_LEFT_PATTERN:  r_left       <= i_cfg_data;
                pmw_pkg::REG_RIGHT_PATTERN: r_right      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pmw_map u_map (
        .i_char    (i_s_tdata[15:0]),
        .i_letters (r_letters),
        .o_code    (w_new_code)
    );

    // cell 0 takes the new code, cell k takes cell k-1; restart clears the rest
    for (genvar k = 0; k < pmw_pkg::NUM_CELLS; k++) begin : g_cell
        pmw_pkg::t_code w_in;
        logic           w_clr;
        if (k == 0) begin : g_head
            assign w_in  = w_new_code;
            assign w_clr = 1'b0;
        end else begin : g_body
            assign w_in  = w_cell_code[k-1];
            assign w_clr = w_restart;
        end
        pmw_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_accept),
            .i_clear     (w_clr),
            .i_code      (w_in),
            .i_left_nib  (r_left[k*pmw_pkg::CODE_BITS +: pmw_pkg::CODE_BITS]),
            .i_right_nib (r_right[k*pmw_pkg::CODE_BITS +: pmw_pkg::CODE_BITS]),
            .o_code      (w_cell_code[k]),
            .o_tap       (w_tap[k])
        );
        assign w_left_word[k*pmw_pkg::CODE_BITS +: pmw_pkg::CODE_BITS]  = w_tap[k].left;
        assign w_right_word[k*pmw_pkg::CODE_BITS +: pmw_pkg::CODE_BITS] = w_tap[k].right;
        assign w_window[k*pmw_pkg::CODE_BITS +: pmw_pkg::CODE_BITS]     = w_cell_code[k];
    end

    // borrow-through subtract: no high bit set means every nibble was nonzero
    assign w_hit = (((w_left_word - pmw_pkg::QUAD_ONES) & pmw_pkg::QUAD_HIGHS) == '0) ||
                   (((w_right_word - pmw_pkg::QUAD_ONES) & pmw_pkg::QUAD_HIGHS) == '0);

    assign w_pos = w_restart ? pmw_pkg::t_pos'(i_s_tdata[39:16]) : r_next_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_next_pos  <= w_pos + pmw_pkg::t_pos'(1);
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_matched <= w_hit;
            r_start   <= w_hit ? pmw_pkg::t_start'(w_pos - pmw_pkg::t_pos'(7)) : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_matched;
    assign o_m_tdata  = r_start;

    // a pending match always reflects a window with every nibble filled
    a_match_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_matched) |->
            (w_window[3:0] != '0 && w_window[7:4] != '0 && w_window[11:8] != '0 &&
             w_window[15:12] != '0 && w_window[19:16] != '0 && w_window[23:20] != '0 &&
             w_window[27:24] != '0 && w_window[31:28] != '0))
        else $error("match reported with an empty window nibble");

    a_code_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_new_code))
        else $error("character code is not one-hot");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_matched) |-> (r_start == '0))
        else $error("match_start nonzero without a match");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ tb/tb_match_pkg.sv @@
// scoreboard for the two-class pattern window matcher: keeps its own copy of the
// letters, patterns, code window and position and predicts one result per character
// depends on pmw_pkg for widths, register indexes and the nibble test constants
`timescale 1ns / 1ps

package tb_match_pkg;

    import pmw_pkg::*;

    typedef struct {
        logic   matched;
        t_start start;
    } match_result_t;

    class match_scoreboard;

        logic [LETTER_BITS-1:0] letters[NUM_LETTERS];
        t_word                  left_mask;
        t_word                  right_mask;
        t_word                  window;
        t_pos                   next_pos;
        match_result_t          expected_q[$];
        int                     mismatches;

        function new();
            letters    = '{7'h41, 7'h42, 7'h43, 7'h44};
            left_mask  = '0;
            right_mask = '0;
            window     = '0;
            next_pos   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] data);
            if (idx <= REG_LETTER_THREE) begin
                letters[int'(idx)] = data[LETTER_BITS-1:0];
            end else if (idx == REG_LEFT_PATTERN) begin
                left_mask = data;
            end else if (idx == REG_RIGHT_PATTERN) begin
                right_mask = data;
            end
        endfunction

        function logic [LETTER_BITS-1:0] to_upper(logic [LETTER_BITS-1:0] c);
            if (c >= 7'h61 && c <= 7'h7A) begin
                return c - 7'h20;
            end
            return c;
        endfunction

        // one-hot letter code; a later register holding the same letter overrides
        function t_code letter_code(logic [15:0] ch);
            t_code code;
            code = '0;
            if (ch < 16'd128) begin
                for (int i = 0; i < NUM_LETTERS; i++) begin
                    if (to_upper(letters[i]) == to_upper(ch[LETTER_BITS-1:0])) begin
                        code = t_code'(1 << i);
                    end
                end
            end
            return code;
        endfunction

        // borrow trick: a nibble that is zero pulls its high bit up
        function bit all_nibbles_set(t_word x);
            t_word d;
            d = x - QUAD_ONES;
            return (d & QUAD_HIGHS) == '0;
        endfunction

        function void note_char(logic [15:0] ch, logic restart, logic [23:0] offset);
            t_pos          pos;
            match_result_t r;
            if (restart) begin
                window = '0;
                pos    = offset[POS_BITS-1:0];
            end else begin
                pos = next_pos;
            end
            window    = {window[WIN_BITS-CODE_BITS-1:0], letter_code(ch)};
            r.matched = all_nibbles_set(window & left_mask) ||
                        all_nibbles_set(window & right_mask);
            r.start   = r.matched ? t_start'(pos - t_pos'(7)) : '0;
            expected_q.push_back(r);
            next_pos = pos + t_pos'(1);
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void check_result(logic matched, logic [23:0] start);
            match_result_t exp_r;
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("result with nothing pending: matched %0b start %06h",
                                       matched, start));
                return;
            end
            exp_r = expected_q.pop_front();
            if (matched !== exp_r.matched) begin
                log_mismatch($sformatf("matched: expected %0b, got %0b", exp_r.matched, matched));
            end
            if (start !== exp_r.start) begin
                log_mismatch($sformatf("match_start: expected %06h, got %06h",
                                       exp_r.start, start));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

@@ tb/tb_top.sv @@
// top-level testbench of two_class_pattern_window_matcher_core: directed and random
// characters over several letter/pattern settings and idling phases, checked per result
// depends on pmw_pkg, tb_match_pkg and the core
`timescale 1ns / 1ps

module tb_top;

    import pmw_pkg::*;
    import tb_match_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;
    localparam int BURST_ITEMS = 50;
    localparam logic [LETTER_BITS-1:0] ASCII_A   = 7'h41;
    localparam logic [LETTER_BITS-1:0] ASCII_Z   = 7'h5A;
    localparam logic [LETTER_BITS-1:0] CASE_STEP = 7'h20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;

    logic [LETTER_BITS-1:0] cur_letter[NUM_LETTERS];
    t_word                  cur_left;
    t_word                  cur_right;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int cycle_count    = 0;

    match_scoreboard sb = new();

    two_class_pattern_window_matcher_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check every completed transaction
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata);
        end
    end

    // receiver ready, with one long hold-off counted here
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request != 0) begin
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_char(logic [15:0] ch, logic restart, logic [23:0] offset);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {offset, ch};
        s_tuser  <= restart;
        do @(posedge clk); while (!s_tready);
        sb.note_char(ch, restart, offset);
        @(negedge clk);
    endtask

    task automatic send_text(string txt, logic [23:0] offset);
        for (int k = 0; k < txt.len(); k++) begin
            send_char({8'd0, txt[k]}, k == 0, (k == 0) ? offset : 24'($urandom));
        end
    endtask

    // write all six registers from the current settings
    task automatic load_config();
        t_reg_idx idx;
        idx = idx.first();
        repeat (idx.num()) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= idx;
            if (idx <= REG_LETTER_THREE) begin
                cfg_data <= {25'd0, cur_letter[int'(idx)]};
            end else if (idx == REG_LEFT_PATTERN) begin
                cfg_data <= cur_left;
            end else begin
                cfg_data <= cur_right;
            end
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(idx, cfg_data);
            @(negedge clk);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic t_word random_pattern();
        t_word p;
        case ($urandom_range(9))
            0: p = '0;
            1: p = '1;
            2: p = $urandom;
            default: begin
                for (int n = 0; n < NUM_CELLS; n++) begin
                    p[n*CODE_BITS +: CODE_BITS] = t_code'($urandom_range(1, 15));
                end
            end
        endcase
        return p;
    endfunction

    task automatic randomize_config();
        for (int i = 0; i < NUM_LETTERS; i++) begin
            if ($urandom_range(99) < 85) begin
                cur_letter[i] = LETTER_BITS'($urandom_range(ASCII_A, ASCII_Z));
            end else begin
                cur_letter[i] = LETTER_BITS'($urandom_range(0, 127));
            end
            // sometimes two registers share a letter
            if (i > 0 && $urandom_range(9) == 0) begin
                cur_letter[i] = cur_letter[$urandom_range(i - 1)];
            end
        end
        cur_left  = random_pattern();
        cur_right = random_pattern();
        load_config();
    endtask

    // a character whose code lands in the allowed mask, now and then noise
    function automatic logic [15:0] fit_char(t_code allowed);
        int                     i;
        logic [LETTER_BITS-1:0] c;
        if (allowed == '0 || $urandom_range(9) == 0) begin
            return 16'($urandom);
        end
        do i = $urandom_range(NUM_LETTERS - 1); while (!allowed[i]);
        c = cur_letter[i];
        if (c >= ASCII_A && c <= ASCII_Z && $urandom_range(1) == 1) begin
            c = c + CASE_STEP;
        end
        return {9'd0, c};
    endfunction

    task automatic random_burst(int n_items);
        int          sent;
        int          len;
        t_word       pat;
        logic [23:0] off;
        sent = 0;
        while (sent < n_items) begin
            pat = $urandom_range(1) ? cur_left : cur_right;
            case ($urandom_range(99) / 15)
                0: begin
                    // stray character continuing whatever is in the window
                    send_char(fit_char(pat[$urandom_range(7)*CODE_BITS +: CODE_BITS]), 1'b0,
                              24'($urandom));
                    sent++;
                end
                1: begin
                    send_char(16'($urandom), 1'($urandom_range(1)), 24'($urandom));
                    sent++;
                end
                default: begin
                    // restart then a window aimed at one of the patterns
                    case ($urandom_range(3))
                        0:       off = 24'($urandom_range(0, 7));
                        1:       off = 24'hFFFFFF - 24'($urandom_range(0, 7));
                        default: off = 24'($urandom);
                    endcase
                    len = $urandom_range(8, 13);
                    for (int k = 0; k < len; k++) begin
                        send_char(fit_char(pat[(7 - (k % 8))*CODE_BITS +: CODE_BITS]), k == 0,
                                  (k == 0) ? off : 24'($urandom));
                    end
                    sent += len;
                end
            endcase
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int idle_pct[4];
        int stall_pct[4];
        idle_pct  = '{0, 68, 0, 6};
        stall_pct = '{0, 0, 68, 6};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lower-case and non-letter registers, window match across a position wrap
        cur_letter = '{7'h41, 7'h5A, 7'h71, 7'h35};  // 'A' 'Z' 'q' '5'
        cur_left   = 32'h1248_1248;
        cur_right  = '0;
        load_config();
        send_text("AzQ5aZq5", 24'hFFFFFC);
        send_char(16'h00C1, 1'b0, 24'h000000);
        send_char(16'hFFFF, 1'b0, 24'hFFFFFF);
        send_char(16'h0000, 1'b0, 24'hFFFFFF);
        send_text("AZQ5A", 24'h000003);
        s_tvalid <= 1'b0;
        wait_idle();

        // all registers on one letter: highest code bit wins
        cur_letter = '{7'h42, 7'h42, 7'h42, 7'h42};
        cur_left   = '1;
        cur_right  = 32'h8888_8888;
        load_config();
        send_text("bbbbbbbbB", 24'h000000);
        s_tvalid <= 1'b0;

        for (int m = 0; m < 4; m++) begin
            for (int b = 0; b < 2; b++) begin
                wait_idle();
                send_idle_pct  = idle_pct[m];
                recv_stall_pct = stall_pct[m];
                randomize_config();
                if (m == 0 && b == 0) begin
                    hold_request = 1;
                end
                random_burst(BURST_ITEMS);
            end
        end

        wait_idle();
        repeat (5) @(negedge clk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
